>>> hdl/r2a_pkg.sv
package r2a_pkg;

	localparam int IN_Q_DEPTH  = 2;
	localparam int OUT_Q_DEPTH = 2;
	localparam int STK_DEPTH   = 32;
	localparam int STK_CW      = $clog2(STK_DEPTH + 1);

	localparam logic [4:0]  RADIX_RST  = 5'd10;
	localparam logic [4:0]  RADIX_MIN  = 5'd2;
	localparam logic [4:0]  RADIX_MAX  = 5'd16;
	localparam logic [63:0] DIG_LO_RST = 64'h3736353433323130;
	localparam logic [63:0] DIG_HI_RST = 64'h6665646362613938;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_HEX_A = 8'h57;	// 'a' - 10

	localparam logic [2:0] NIL_LAST = 3'd4;

	typedef enum logic [1:0] {
		OP_UNSIGNED = 2'd0,
		OP_SIGNED   = 2'd1,
		OP_POINTER  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		REG_RADIX  = 2'd0,
		REG_DIG_LO = 2'd1,
		REG_DIG_HI = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		K_PLAIN,
		K_NEG,
		K_PTR,
		K_NIL
	} kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PREFIX,
		BK_GEN,
		BK_FIX,
		BK_EMIT
	} bk_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] mag;
	} q_entry_t;

	typedef struct packed {
		logic [4:0]  radix;	// already clamped to 2..16
		logic [63:0] dig_lo;
		logic [63:0] dig_hi;
	} cfg_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} out_entry_t;

	// floor(2^32 / r); quotient estimate is exact or one low
	function automatic logic [31:0] recip(input logic [4:0] r);
		logic [31:0] m;
		case (r)
			5'd2:    m = 32'h8000_0000;
			5'd3:    m = 32'h5555_5555;
			5'd4:    m = 32'h4000_0000;
			5'd5:    m = 32'h3333_3333;
			5'd6:    m = 32'h2AAA_AAAA;
			5'd7:    m = 32'h2492_4924;
			5'd8:    m = 32'h2000_0000;
			5'd9:    m = 32'h1C71_C71C;
			5'd10:   m = 32'h1999_9999;
			5'd11:   m = 32'h1745_D174;
			5'd12:   m = 32'h1555_5555;
			5'd13:   m = 32'h13B1_3B13;
			5'd14:   m = 32'h1249_2492;
			5'd15:   m = 32'h1111_1111;
			default: m = 32'h1000_0000;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10)
			c = CH_ZERO + 8'(d);
		else
			c = CH_HEX_A + 8'(d);
		return c;
	endfunction

	function automatic logic [7:0] nil_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0:    c = CH_LPAR;
			3'd1:    c = CH_N;
			3'd2:    c = CH_I;
			3'd3:    c = CH_L;
			default: c = CH_RPAR;
		endcase
		return c;
	endfunction

endpackage

>>> hdl/r2a_fifo.sv
module r2a_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             wr, rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (rd)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> hdl/r2a_front.sv
module r2a_front #(
	parameter int Q_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        opcode,
	input  logic [63:0]       value,
	output r2a_pkg::q_entry_t entry,
	output logic              empty,
	input  logic              pop
);
	import r2a_pkg::*;

	q_entry_t   cls;
	logic [31:0] lo;

	assign lo = value[31:0];

	// only the high opcode bit selects pointer mode
	always_comb begin
		cls.kind = K_PLAIN;
		cls.mag  = {32'd0, lo};
		if (opcode[1]) begin
			cls.mag  = value;
			cls.kind = (value == 64'd0) ? K_NIL : K_PTR;
		end else if (opcode == OP_SIGNED && lo[31]) begin
			cls.kind = K_NEG;
			cls.mag  = {32'd0, 32'd0 - lo};
		end
	end

	r2a_fifo #(
		.WIDTH ($bits(q_entry_t)),
		.DEPTH (Q_DEPTH)
	) u_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cls),
		.full   (full),
		.pop    (pop),
		.dout   (entry),
		.empty  (empty)
	);

endmodule

>>> hdl/r2a_back.sv
module r2a_back (
	input  logic                clk,
	input  logic                arst_n,
	input  r2a_pkg::cfg_t       cfg,
	input  r2a_pkg::q_entry_t   in_entry,
	input  logic                in_empty,
	output logic                in_pop,
	input  logic                out_full,
	output logic                out_push,
	output r2a_pkg::out_entry_t out_entry
);
	import r2a_pkg::*;

	bk_state_t         state_q, state_nxt;
	kind_t             kind_q;
	logic [63:0]       mag_q, mag_nxt;
	logic [31:0]       q0_q;
	logic [2:0]        pre_cnt_q;
	logic [3:0]        stk_q [STK_DEPTH];
	logic [STK_CW-1:0] depth_q;

	logic        is_ptr, fast, pre_end;
	logic [2:0]  sh;
	logic [3:0]  mask;
	logic [3:0]  fast_digit;
	logic [63:0] fast_mag;
	logic [63:0] prod;
	logic [36:0] qr;
	logic [31:0] rem_full;
	logic [4:0]  rem5;
	logic        fix_hi;
	logic [3:0]  fix_digit;
	logic [31:0] fix_q;
	logic [3:0]  digit;
	logic [63:0] dword;
	logic [7:0]  prefix_char, digit_char;
	logic        stk_push, stk_pop, mul_load;

	assign is_ptr = (kind_q == K_PTR);

	// power-of-two radix and hex pointers take one digit per cycle by shifting
	always_comb begin
		case (cfg.radix)
			5'd2:    sh = 3'd1;
			5'd4:    sh = 3'd2;
			5'd8:    sh = 3'd3;
			default: sh = 3'd4;
		endcase
		if (is_ptr)
			sh = 3'd4;
		fast = is_ptr || $onehot(cfg.radix);
		mask = is_ptr ? 4'hF : 4'(cfg.radix - 5'd1);
	end

	assign fast_digit = mag_q[3:0] & mask;
	assign fast_mag   = mag_q >> sh;

	// other radices: reciprocal estimate, then one correction step
	assign prod      = 64'(mag_q[31:0]) * 64'(recip(cfg.radix));
	assign qr        = 37'(q0_q) * 37'(cfg.radix);
	assign rem_full  = mag_q[31:0] - qr[31:0];
	assign rem5      = rem_full[4:0];
	assign fix_hi    = (rem5 >= cfg.radix);
	assign fix_digit = fix_hi ? 4'(rem5 - cfg.radix) : rem5[3:0];
	assign fix_q     = q0_q + 32'(fix_hi);

	always_comb begin
		case (kind_q)
			K_NIL:   begin
				prefix_char = nil_char(pre_cnt_q);
				pre_end     = (pre_cnt_q == NIL_LAST);
			end
			K_PTR:   begin
				prefix_char = (pre_cnt_q == 3'd0) ? CH_ZERO : CH_X;
				pre_end     = (pre_cnt_q == 3'd1);
			end
			default: begin
				prefix_char = CH_MINUS;
				pre_end     = 1'b1;
			end
		endcase
	end

	assign dword      = stk_q[0][3] ? cfg.dig_hi : cfg.dig_lo;
	assign digit_char = is_ptr ? hex_char(stk_q[0]) : dword[{stk_q[0][2:0], 3'b000} +: 8];

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!in_empty)
					state_nxt = (in_entry.kind == K_PLAIN) ? BK_GEN : BK_PREFIX;
			end
			BK_PREFIX: begin
				if (!out_full && pre_end)
					state_nxt = (kind_q == K_NIL) ? BK_IDLE : BK_GEN;
			end
			BK_GEN: begin
				if (!fast)
					state_nxt = BK_FIX;
				else if (fast_mag == 64'd0)
					state_nxt = BK_EMIT;
			end
			BK_FIX: begin
				state_nxt = (fix_q == 32'd0) ? BK_EMIT : BK_GEN;
			end
			BK_EMIT: begin
				if (!out_full && depth_q == STK_CW'(1))
					state_nxt = BK_IDLE;
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_pop              = 1'b0;
		out_push            = 1'b0;
		out_entry.character = prefix_char;
		out_entry.last      = 1'b0;
		stk_push            = 1'b0;
		stk_pop             = 1'b0;
		mul_load            = 1'b0;
		digit               = fast_digit;
		mag_nxt             = fast_mag;
		case (state_q)
			BK_IDLE: begin
				in_pop = !in_empty;
			end
			BK_PREFIX: begin
				out_push       = !out_full;
				out_entry.last = (kind_q == K_NIL) && pre_end;
			end
			BK_GEN: begin
				stk_push = fast;
				mul_load = !fast;
			end
			BK_FIX: begin
				stk_push = 1'b1;
				digit    = fix_digit;
				mag_nxt  = {32'd0, fix_q};
			end
			BK_EMIT: begin
				out_push            = !out_full;
				stk_pop             = !out_full;
				out_entry.character = digit_char;
				out_entry.last      = (depth_q == STK_CW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			kind_q    <= K_PLAIN;
			pre_cnt_q <= '0;
			depth_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_pop) begin
				kind_q    <= in_entry.kind;
				pre_cnt_q <= '0;
			end else if (state_q == BK_PREFIX && out_push) begin
				pre_cnt_q <= pre_cnt_q + 1'b1;
			end
			if (stk_push)
				depth_q <= depth_q + 1'b1;
			else if (stk_pop)
				depth_q <= depth_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop)
			mag_q <= in_entry.mag;
		else if (stk_push)
			mag_q <= mag_nxt;
		if (mul_load)
			q0_q <= prod[63:32];
		// digit stack: lowest digit pushed first, top read at entry 0
		if (stk_push) begin
			stk_q[0] <= digit;
			for (int i = 1; i < STK_DEPTH; i++)
				stk_q[i] <= stk_q[i-1];
		end else if (stk_pop) begin
			for (int i = 0; i < STK_DEPTH - 1; i++)
				stk_q[i] <= stk_q[i+1];
		end
	end

endmodule

>>> hdl/radix_integer_to_ascii.sv
// Items wait in the input queue; the sequencer takes one at a time and, once its last
// character is pushed, the next. A sign, 0x or (nil) prefix goes out first; any digits are
// then stacked, by shifting for hex pointers and power-of-two radices, otherwise by
// reciprocal multiply, then correct, and emitted most significant first.
// Reset clears both queues and the sequencer; radix returns to 10, digits to "0..9a..f".
module radix_integer_to_ascii #(
	parameter int IN_Q_DEPTH  = r2a_pkg::IN_Q_DEPTH,
	parameter int OUT_Q_DEPTH = r2a_pkg::OUT_Q_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [63:0] value,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  character,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import r2a_pkg::*;

	logic [4:0]  radix_q;
	logic [63:0] dig_lo_q, dig_hi_q;
	cfg_t        cfg;
	q_entry_t    fq_entry;
	logic        fq_empty, fq_pop;
	out_entry_t  bk_out, oq_out;
	logic        oq_push, oq_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RADIX_RST;
			dig_lo_q <= DIG_LO_RST;
			dig_hi_q <= DIG_HI_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIX:  radix_q  <= cfg_data[4:0];
				REG_DIG_LO: dig_lo_q <= cfg_data;
				REG_DIG_HI: dig_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.radix = radix_q;
		if (radix_q < RADIX_MIN)
			cfg.radix = RADIX_MIN;
		else if (radix_q > RADIX_MAX)
			cfg.radix = RADIX_MAX;
		cfg.dig_lo = dig_lo_q;
		cfg.dig_hi = dig_hi_q;
	end

	r2a_front #(
		.Q_DEPTH (IN_Q_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.opcode (opcode),
		.value  (value),
		.entry  (fq_entry),
		.empty  (fq_empty),
		.pop    (fq_pop)
	);

	r2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_entry  (fq_entry),
		.in_empty  (fq_empty),
		.in_pop    (fq_pop),
		.out_full  (oq_full),
		.out_push  (oq_push),
		.out_entry (bk_out)
	);

	r2a_fifo #(
		.WIDTH ($bits(out_entry_t)),
		.DEPTH (OUT_Q_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.din    (bk_out),
		.full   (oq_full),
		.pop    (pop),
		.dout   (oq_out),
		.empty  (empty)
	);

	assign character = oq_out.character;
	assign last      = oq_out.last;

endmodule

>>> hdl/r2a_checker.sv
module r2a_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] character,
	input logic       last
);
	logic [7:0] pend_q;	// items taken whose last character is not yet out
	logic [5:0] chars_q;	// characters of the current item already out
	logic       item_in, item_out, ch_out;

	assign item_in  = push && !full;
	assign ch_out   = pop && !empty;
	assign item_out = ch_out && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			chars_q <= '0;
		end else begin
			if (item_in && !item_out)
				pend_q <= pend_q + 1'b1;
			else if (item_out && !item_in)
				pend_q <= pend_q - 1'b1;
			if (item_out)
				chars_q <= '0;
			else if (ch_out)
				chars_q <= chars_q + 1'b1;
		end
	end

	a_rst_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result side not empty during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(character) && $stable(last)))
		else $error("waiting result changed before it was taken");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pend_q != 8'd0))
		else $error("result shown with no item outstanding");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		ch_out |-> (chars_q < 6'd33 && (last || chars_q < 6'd32)))
		else $error("item produced more than 33 characters");

endmodule

bind radix_integer_to_ascii r2a_checker u_r2a_checker (.*);

>>> bench/r2a_text_checker.sv
module r2a_text_checker
	import r2a_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  opcode,
	input  logic [63:0] value,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  character,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          mismatches,
	output int          chars_waiting,
	output int          chars_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	text_char_t  expected_text[$];
	logic [4:0]  radix_reg;
	logic [63:0] digits_lo;
	logic [63:0] digits_hi;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [63:0] word;
		word = d[3] ? digits_hi : digits_lo;
		return word[d[2:0]*8 +: 8];
	endfunction

	// queues the characters one input item should produce
	function automatic void format_number(input logic [1:0] op, input logic [63:0] v);
		string       hex_lower;
		logic [7:0]  text[$];
		logic [7:0]  digits[$];
		logic [31:0] mag;
		logic [31:0] base;
		int          msn;
		hex_lower = "0123456789abcdef";
		// high opcode bit alone selects pointer mode
		if (op[1]) begin
			if (v == 64'd0) begin
				text.push_back(CH_LPAR);
				text.push_back(CH_N);
				text.push_back(CH_I);
				text.push_back(CH_L);
				text.push_back(CH_RPAR);
			end else begin
				text.push_back(CH_ZERO);
				text.push_back(CH_X);
				msn = 15;
				while (v[msn*4 +: 4] == 4'd0)
					msn--;
				for (int i = msn; i >= 0; i--)
					text.push_back(hex_lower[v[i*4 +: 4]]);
			end
		end else begin
			if (radix_reg < 5'd2)
				base = 32'd2;
			else if (radix_reg > 5'd16)
				base = 32'd16;
			else
				base = 32'(radix_reg);
			mag = v[31:0];
			if (op == OP_SIGNED && mag[31]) begin
				text.push_back(CH_MINUS);
				mag = -mag;
			end
			do begin
				digits.push_front(digit_char(4'(mag % base)));
				mag = mag / base;
			end while (mag != 32'd0);
			foreach (digits[i])
				text.push_back(digits[i]);
		end
		foreach (text[i])
			expected_text.push_back('{ch: text[i], last: (i == text.size() - 1)});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			radix_reg = RADIX_RST;
			digits_lo = DIG_LO_RST;
			digits_hi = DIG_HI_RST;
			expected_text.delete();
			mismatches = 0;
			chars_waiting = 0;
			chars_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RADIX:  radix_reg = cfg_data[4:0];
					REG_DIG_LO: digits_lo = cfg_data;
					REG_DIG_HI: digits_hi = cfg_data;
					default: ;
				endcase
			end
			// pop before push: a character can never belong to an item taken at the same edge
			if (pop && !empty) begin
				chars_checked++;
				if (expected_text.size() == 0) begin
					if (mismatches < 10)
						$display("[%0t] unexpected character 0x%02h last=%b",
							$realtime, character, last);
					mismatches++;
				end else begin
					want = expected_text.pop_front();
					if (character !== want.ch || last !== want.last) begin
						if (mismatches < 10)
							$display("[%0t] char mismatch: want 0x%02h last=%b, got 0x%02h last=%b",
								$realtime, want.ch, want.last, character, last);
						mismatches++;
					end
				end
			end
			if (push && !full)
				format_number(opcode, value);
			chars_waiting = expected_text.size();
		end
	end

endmodule

>>> bench/radix_integer_to_ascii_tb.sv
module radix_integer_to_ascii_tb;
	import r2a_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CYCLE_LIMIT   = 600000;
	localparam int         HOLD_CYCLES   = 400;
	localparam int         SETTLE_CYCLES = 16;
	localparam logic [1:0] REG_SPARE     = 2'd3;
	localparam logic [1:0] OP_PTR_ALIAS  = 2'd3;	// decodes as pointer mode

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  opcode;
	logic [63:0] value;
	logic        empty;
	logic        pop;
	logic [7:0]  character;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	int mismatches;
	int chars_waiting;
	int chars_checked;
	int send_gap_max = 8;
	int pop_gap_max = 8;
	int holds_asked = 0;
	int holds_served = 0;
	int cycles = 0;
	int cfg_writes = 0;
	int items_by_op [4] = '{default: 0};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	radix_integer_to_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	r2a_text_checker text_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.value         (value),
		.empty         (empty),
		.pop           (pop),
		.character     (character),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.chars_waiting (chars_waiting),
		.chars_checked (chars_checked)
	);

	task automatic send(input logic [1:0] op, input logic [63:0] v);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		opcode = op;
		value = v;
		do @(posedge clk); while (full);
		items_by_op[op]++;
	endtask

	task automatic drain();
		@(negedge clk);
		push = 1'b0;
		while (chars_waiting != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_writes++;
	endtask

	task automatic configure(input logic [63:0] r, input logic [63:0] lo, input logic [63:0] hi);
		drain();
		write_reg(REG_RADIX, r);
		write_reg(REG_DIG_LO, lo);
		write_reg(REG_DIG_HI, hi);
	endtask

	// result side: random stalls per character, plus a long hold when asked
	initial begin
		int gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (holds_served < holds_asked) begin
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served++;
			end
			gap = $urandom_range(0, pop_gap_max);
			if (gap != 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d characters outstanding",
			cycles, chars_waiting);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [63:0] r;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] v;
		logic [1:0]  op;
		arst_n = 1'b0;
		push = 1'b0;
		opcode = OP_UNSIGNED;
		value = 64'd0;
		cfg_valid = 1'b0;
		cfg_index = REG_RADIX;
		cfg_data = 64'd0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: decimal, standard digits
		send(OP_UNSIGNED, 64'd0);
		send(OP_UNSIGNED, 64'h0000_0000_FFFF_FFFF);
		send(OP_UNSIGNED, 64'hFFFF_FFFF_0000_0009);	// upper half ignored
		send(OP_SIGNED, 64'h0000_0000_8000_0000);	// most negative
		send(OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
		send(OP_SIGNED, 64'h0000_0000_7FFF_FFFF);
		send(OP_SIGNED, 64'd0);
		send(OP_POINTER, 64'd0);
		send(OP_POINTER, 64'hFFFF_FFFF_FFFF_FFFF);
		send(OP_POINTER, 64'd1);
		send(OP_POINTER, 64'h8000_0000_0000_0000);
		send(OP_PTR_ALIAS, 64'd0);
		send(OP_PTR_ALIAS, 64'h0123_4567_89AB_CDEF);

		// binary with junk above the radix field; all-zero / all-one digit bytes
		configure(64'hFFFF_FFFF_FFFF_FFE2, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send(OP_SIGNED, 64'h0000_0000_8000_0000);
		send(OP_UNSIGNED, 64'h0000_0000_FFFF_FFFF);
		send(OP_POINTER, 64'h0000_0000_0000_00F0);	// fixed hex table

		// radix 0 and 1 act as 2
		configure(64'd0, DIG_LO_RST, DIG_HI_RST);
		send(OP_UNSIGNED, 64'd5);
		configure(64'd1, DIG_LO_RST, DIG_HI_RST);
		send(OP_SIGNED, 64'h0000_0000_FFFF_FFFA);

		// radix 17 and 31 act as 16, with a letter digit table, A for 0 up to P for 15
		configure(64'd31, "HGFEDCBA", "PONMLKJI");
		send(OP_UNSIGNED, 64'h0000_0000_DEAD_BEEF);
		send(OP_SIGNED, 64'h0000_0000_8000_0001);
		configure(64'd17, "HGFEDCBA", "PONMLKJI");
		send(OP_UNSIGNED, 64'h0000_0001_0000_0010);

		// writes to the unused index change nothing
		drain();
		write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
		send(OP_UNSIGNED, 64'd12345);

		for (int p = 0; p < 7; p++) begin
			r = {$urandom, $urandom};
			if ($urandom_range(0, 3) == 0)
				r[4:0] = 5'($urandom_range(0, 31));
			else
				r[4:0] = 5'($urandom_range(2, 16));
			if ($urandom_range(0, 2) == 0) begin
				lo = DIG_LO_RST;
				hi = DIG_HI_RST;
			end else begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
			end
			configure(r, lo, hi);
			send_gap_max = (p % 3 == 1 || p == 4) ? 0 : 8;
			pop_gap_max = (p % 3 == 2 || p == 4) ? 0 : 8;
			// long result stall while items keep coming: the block backs up
			if (p == 3)
				holds_asked++;
			for (int k = 0; k < 13; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: op = OP_UNSIGNED;
					3, 4, 5: op = OP_SIGNED;
					6, 7, 8: op = OP_POINTER;
					default: op = OP_PTR_ALIAS;
				endcase
				v = {$urandom, $urandom};
				case ($urandom_range(0, 7))
					0:       v = 64'd0;
					1, 2:    v = v >> $urandom_range(1, 63);
					3:       v[31:0] = {v[0], 30'd0, v[1]} | {1'b0, {31{v[2]}}};
					default: ;
				endcase
				send(op, v);
			end
		end

		drain();
		$display("Covered %0d items (%0d unsigned, %0d signed, %0d pointer, %0d alias), %0d chars",
			items_by_op[0] + items_by_op[1] + items_by_op[2] + items_by_op[3],
			items_by_op[0], items_by_op[1], items_by_op[2], items_by_op[3], chars_checked);
		$display("%0d register writes incl. radix clamping at both ends; %0d-cycle output stall",
			cfg_writes, HOLD_CYCLES);
		if (mismatches == 0 && chars_waiting == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
